@@ rtl/lidar_spherical_projection_core_defines.svh @@
// Assertion macros used by the lidar projection core.
`ifndef LIDAR_SPHERICAL_PROJECTION_CORE_DEFINES_SVH
`define LIDAR_SPHERICAL_PROJECTION_CORE_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define LSP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LSP_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

@@ rtl/lsp_pkg.sv @@
// Shared types and constants of the lidar spherical projection core.
package lsp_pkg;

	localparam int SCALE_W    = 32;  // coordinates scaled to this width
	localparam int SQRT_IN_W  = 64;
	localparam int SQRT_OUT_W = 32;
	localparam int SQRT_REM_W = 34;
	localparam int CORDIC_W   = 36;
	localparam int ANGLE_W    = 34;  // binary angle, full turn = 2^32
	localparam int TABLE_LEN  = 24;
	localparam int TABLE_IDX_W = 5;

	localparam int RANGE_W  = 20;
	localparam int COL_W    = 12;
	localparam int ROW_W    = 8;
	localparam int INDEX_W  = 20;
	localparam int FOV_W    = 16;
	localparam int FOV_MAG_W = 17;
	localparam int WIDTH_W  = 13;
	localparam int HEIGHT_W = 9;
	localparam int H_SPAN_W = 25;
	localparam int DIV_STEPS = 8;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 256;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FOV_UP       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FOV_DOWN     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

	localparam logic [FOV_W-1:0]    FOV_UP_RESET   = 16'd768;
	localparam logic [FOV_W-1:0]    FOV_DOWN_RESET = 16'hE700;  // -6400
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = 13'd2048;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 9'd64;

	localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [ANGLE_W:0]   HALF_TURN    = 35'sd2147483648;
	localparam logic signed [17:0]        TURN_DEG256  = 18'sd92160;

	// atan(2^-i) as binary angle, rounded to nearest
	localparam logic [31:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// configuration values derived for the datapath
	typedef struct packed {
		logic [WIDTH_W-1:0]   w_eff;
		logic [HEIGHT_W-1:0]  h_eff;
		logic [FOV_MAG_W-1:0] up_mag;
		logic [FOV_MAG_W-1:0] fov_sum;
		logic [H_SPAN_W-1:0]  h_span;
		logic                 col_zero;
		logic                 row_zero;
	} cfg_t;

endpackage

@@ rtl/lsp_sqrt_pipe.sv @@
// Two-lane pipelined integer square root, one root bit per stage.
module lsp_sqrt_pipe #(
	parameter int SIDE_W = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [lsp_pkg::SQRT_IN_W-1:0]      rad_a,
	input  logic [lsp_pkg::SQRT_IN_W-1:0]      rad_b,
	input  logic [SIDE_W-1:0]                  side_in,
	output logic                               out_valid,
	output logic [lsp_pkg::SQRT_OUT_W-1:0]     root_a,
	output logic [lsp_pkg::SQRT_OUT_W-1:0]     root_b,
	output logic [SIDE_W-1:0]                  side_out
);

	localparam int STAGES = lsp_pkg::SQRT_OUT_W;
	localparam int IW = lsp_pkg::SQRT_IN_W;
	localparam int RW = lsp_pkg::SQRT_REM_W;

	typedef struct packed {
		logic [IW-1:0]     rad;
		logic [RW-1:0]     rem;
		logic [STAGES-1:0] root;
	} lane_t;

	function automatic lane_t sqrt_step(lane_t cur);
		lane_t         nxt;
		logic [RW+1:0] acc;
		logic [RW+1:0] trial;
		acc   = {cur.rem, cur.rad[IW-1 -: 2]};
		trial = (RW+2)'({cur.root, 2'b01});
		nxt.rad = {cur.rad[IW-3:0], 2'b00};
		if (acc >= trial) begin
			nxt.rem  = RW'(acc - trial);
			nxt.root = {cur.root[STAGES-2:0], 1'b1};
		end else begin
			nxt.rem  = acc[RW-1:0];
			nxt.root = {cur.root[STAGES-2:0], 1'b0};
		end
		return nxt;
	endfunction

	lane_t             a_s [0:STAGES-1];
	lane_t             b_s [0:STAGES-1];
	lane_t             a_nx [0:STAGES-1];
	lane_t             b_nx [0:STAGES-1];
	logic [SIDE_W-1:0] sd_s [0:STAGES-1];
	logic [STAGES-1:0] v_s;

	always_comb begin
		a_nx[0] = sqrt_step('{rad: rad_a, rem: '0, root: '0});
		b_nx[0] = sqrt_step('{rad: rad_b, rem: '0, root: '0});
		for (int k = 1; k < STAGES; k++) begin
			a_nx[k] = sqrt_step(a_s[k-1]);
			b_nx[k] = sqrt_step(b_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_in;
			for (int k = 0; k < STAGES; k++) begin
				a_s[k] <= a_nx[k];
				b_s[k] <= b_nx[k];
			end
			for (int k = 1; k < STAGES; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign root_a    = a_s[STAGES-1].root;
	assign root_b    = b_s[STAGES-1].root;
	assign side_out  = sd_s[STAGES-1];

endmodule

@@ rtl/lsp_cordic_pipe.sv @@
// Pipelined vectoring CORDIC: atan2(y, x) as a binary angle.
module lsp_cordic_pipe #(
	parameter int ITERATIONS = 16,
	parameter int SIDE_W     = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [lsp_pkg::CORDIC_W-1:0] x_in,
	input  logic signed [lsp_pkg::CORDIC_W-1:0] y_in,
	input  logic [SIDE_W-1:0]                   side_in,
	output logic                                out_valid,
	output logic signed [lsp_pkg::ANGLE_W-1:0]  angle,
	output logic [SIDE_W-1:0]                   side_out
);

	localparam int CW = lsp_pkg::CORDIC_W;
	localparam int AW = lsp_pkg::ANGLE_W;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] ang;
		logic                 zero;
	} vec_t;

	function automatic vec_t rotate(vec_t v, logic [lsp_pkg::TABLE_IDX_W-1:0] idx);
		vec_t                 r;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [AW-1:0] da;
		dx = v.y >>> idx;
		dy = v.x >>> idx;
		da = $signed(AW'(lsp_pkg::ATAN_TABLE[idx]));
		r.zero = v.zero;
		if (!v.y[CW-1]) begin
			r.x   = v.x + dx;
			r.y   = v.y - dy;
			r.ang = v.ang + da;
		end else begin
			r.x   = v.x - dx;
			r.y   = v.y + dy;
			r.ang = v.ang - da;
		end
		return r;
	endfunction

	vec_t                pre;
	vec_t                st_s [0:ITERATIONS];
	vec_t                nx   [0:ITERATIONS];
	logic [SIDE_W-1:0]   sd_s [0:ITERATIONS];
	logic [ITERATIONS:0] v_s;

	// fold the left half plane into the right one
	always_comb begin
		pre.zero = (x_in == '0) && (y_in == '0);
		if (x_in[CW-1]) begin
			if (!y_in[CW-1]) begin
				pre.x   = y_in;
				pre.y   = -x_in;
				pre.ang = lsp_pkg::QUARTER_TURN;
			end else begin
				pre.x   = -y_in;
				pre.y   = x_in;
				pre.ang = -lsp_pkg::QUARTER_TURN;
			end
		end else begin
			pre.x   = x_in;
			pre.y   = y_in;
			pre.ang = '0;
		end
	end

	always_comb begin
		nx[0] = pre;
		for (int i = 1; i <= ITERATIONS; i++) begin
			nx[i] = rotate(st_s[i-1], lsp_pkg::TABLE_IDX_W'(i - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[ITERATIONS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_in;
			for (int i = 0; i <= ITERATIONS; i++) begin
				st_s[i] <= nx[i];
			end
			for (int i = 1; i <= ITERATIONS; i++) begin
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	assign out_valid = v_s[ITERATIONS];
	assign angle     = st_s[ITERATIONS].zero ? '0 : st_s[ITERATIONS].ang;
	assign side_out  = sd_s[ITERATIONS];

endmodule

@@ rtl/lsp_pixel_map.sv @@
// Angle to pixel mapping: column, row (pipelined divide), flat index, output register.
module lsp_pixel_map (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic signed [lsp_pkg::ANGLE_W-1:0] yaw,
	input  logic signed [lsp_pkg::ANGLE_W-1:0] pitch,
	input  logic [lsp_pkg::RANGE_W-1:0]        range_in,
	input  logic                               last_in,
	input  lsp_pkg::cfg_t                      cfg,
	output logic                               out_valid,
	output logic [lsp_pkg::RANGE_W-1:0]        point_range,
	output logic [lsp_pkg::COL_W-1:0]          pixel_column,
	output logic [lsp_pkg::ROW_W-1:0]          pixel_row,
	output logic [lsp_pkg::INDEX_W-1:0]        pixel_index,
	output logic                               last_out
);

	localparam int DS  = lsp_pkg::DIV_STEPS;
	localparam int AW  = lsp_pkg::ANGLE_W;
	localparam int RNW = lsp_pkg::RANGE_W;
	localparam int CLW = lsp_pkg::COL_W;
	localparam int RWW = lsp_pkg::ROW_W;
	localparam int HSW = lsp_pkg::H_SPAN_W;
	localparam int WW  = lsp_pkg::WIDTH_W;
	localparam int CPW = WW + AW + 2;    // column product
	localparam int PPW = AW + 18;        // pitch times turn
	localparam int NW  = 54;             // row numerator
	localparam int HNW = 64;

	// s1: products
	logic                  v_s1;
	logic signed [CPW-1:0] colp_s1;
	logic signed [PPW-1:0] pitp_s1;
	logic [RNW-1:0]        rng_s1;
	logic                  last_s1;
	logic signed [AW:0]    yaw_off;

	assign yaw_off = lsp_pkg::HALF_TURN - (AW+1)'(yaw);

	// s2: column done, row numerator
	logic                  v_s2;
	logic [CLW-1:0]        col_s2;
	logic signed [NW-1:0]  num_s2;
	logic [RNW-1:0]        rng_s2;
	logic                  last_s2;
	logic signed [CPW-33:0] col_raw;
	logic [CLW-1:0]        col_d;

	assign col_raw = $signed(colp_s1[CPW-1:32]);

	always_comb begin
		if (cfg.col_zero || col_raw[CPW-33]) begin
			col_d = '0;
		end else if (col_raw >= $signed((CPW-32)'({1'b0, cfg.w_eff}))) begin
			col_d = CLW'(cfg.w_eff - WW'(1));
		end else begin
			col_d = col_raw[CLW-1:0];
		end
	end

	// s3: height times numerator
	logic                  v_s3;
	logic signed [HNW-1:0] hn_s3;
	logic [CLW-1:0]        col_s3;
	logic [RNW-1:0]        rng_s3;
	logic                  last_s3;

	// s4: scaled quotient, range checks
	logic                  v_s4;
	logic [HSW-1:0]        rem_s4;
	logic                  neg_s4;
	logic                  big_s4;
	logic [CLW-1:0]        col_s4;
	logic [RNW-1:0]        rng_s4;
	logic                  last_s4;
	logic signed [31:0]    q_d;

	assign q_d = $signed(hn_s3[HNW-1:32]);

	// divide stages
	logic [HSW-1:0] dv_rem  [0:DS-1];
	logic [RWW-1:0] dv_quo  [0:DS-1];
	logic [CLW-1:0] dv_col  [0:DS-1];
	logic [RNW-1:0] dv_rng  [0:DS-1];
	logic [HSW-1:0] src_rem [0:DS-1];
	logic [RWW-1:0] src_quo [0:DS-1];
	logic [HSW-1:0] nx_rem  [0:DS-1];
	logic [RWW-1:0] nx_quo  [0:DS-1];
	logic [DS-1:0]  dv_neg;
	logic [DS-1:0]  dv_big;
	logic [DS-1:0]  dv_last;
	logic [DS-1:0]  dv_v;

	always_comb begin
		src_rem[0] = rem_s4;
		src_quo[0] = '0;
		for (int j = 1; j < DS; j++) begin
			src_rem[j] = dv_rem[j-1];
			src_quo[j] = dv_quo[j-1];
		end
		for (int j = 0; j < DS; j++) begin
			if (src_rem[j] >= (HSW'(cfg.fov_sum) << (DS - 1 - j))) begin
				nx_rem[j] = src_rem[j] - (HSW'(cfg.fov_sum) << (DS - 1 - j));
				nx_quo[j] = {src_quo[j][RWW-2:0], 1'b1};
			end else begin
				nx_rem[j] = src_rem[j];
				nx_quo[j] = {src_quo[j][RWW-2:0], 1'b0};
			end
		end
	end

	// s13: row select, flat index
	logic                v_s13;
	logic [RNW-1:0]      rng_s13;
	logic [CLW-1:0]      col_s13;
	logic [RWW-1:0]      row_s13;
	logic [RNW-1:0]      idx_s13;
	logic                last_s13;
	logic [RWW-1:0]      row_d;

	always_comb begin
		if (cfg.row_zero || dv_neg[DS-1]) begin
			row_d = '0;
		end else if (dv_big[DS-1]) begin
			row_d = RWW'(cfg.h_eff - lsp_pkg::HEIGHT_W'(1));
		end else begin
			row_d = dv_quo[DS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			dv_v  <= '0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			dv_v  <= {dv_v[DS-2:0], v_s4};
			v_s13 <= dv_v[DS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			colp_s1 <= $signed({1'b0, cfg.w_eff}) * yaw_off;
			pitp_s1 <= pitch * lsp_pkg::TURN_DEG256;
			rng_s1  <= range_in;
			last_s1 <= last_in;

			col_s2  <= col_d;
			num_s2  <= $signed({5'b0, cfg.up_mag, 32'b0}) - NW'(pitp_s1);
			rng_s2  <= rng_s1;
			last_s2 <= last_s1;

			hn_s3   <= $signed({1'b0, cfg.h_eff}) * num_s2;
			col_s3  <= col_s2;
			rng_s3  <= rng_s2;
			last_s3 <= last_s2;

			rem_s4  <= q_d[HSW-1:0];
			neg_s4  <= q_d[31];
			big_s4  <= !q_d[31] && (q_d[30:0] >= 31'(cfg.h_span));
			col_s4  <= col_s3;
			rng_s4  <= rng_s3;
			last_s4 <= last_s3;

			dv_neg  <= {dv_neg[DS-2:0], neg_s4};
			dv_big  <= {dv_big[DS-2:0], big_s4};
			dv_last <= {dv_last[DS-2:0], last_s4};
			dv_col[0] <= col_s4;
			dv_rng[0] <= rng_s4;
			for (int j = 0; j < DS; j++) begin
				dv_rem[j] <= nx_rem[j];
				dv_quo[j] <= nx_quo[j];
			end
			for (int j = 1; j < DS; j++) begin
				dv_col[j] <= dv_col[j-1];
				dv_rng[j] <= dv_rng[j-1];
			end

			rng_s13  <= dv_rng[DS-1];
			col_s13  <= dv_col[DS-1];
			row_s13  <= row_d;
			idx_s13  <= RNW'(21'(row_d) * 21'(cfg.w_eff) + 21'(dv_col[DS-1]));
			last_s13 <= dv_last[DS-1];
		end
	end

	assign out_valid    = v_s13;
	assign point_range  = rng_s13;
	assign pixel_column = col_s13;
	assign pixel_row    = row_s13;
	assign pixel_index  = idx_s13;
	assign last_out     = last_s13;

endmodule

@@ rtl/lidar_spherical_projection_core.sv @@
// Lidar spherical projection core: one point per clock in, one pixel result per point out.
//
// Takes one lidar point per cycle (x, y, z in 1/256 m) and returns its range, image
// column from azimuth, image row from elevation and the flat pixel index, in order.
// Fully pipelined: one transaction per clock in both directions unless the output
// stalls. Stages: 1 square stage, 32 square-root stages, one pre-rotation plus
// ANGLE_ITERATIONS CORDIC stages, 13 mapping stages including an 8-stage row
// divider and the output register. The 32-stage root and the CORDIC chain set the
// latency. A stall on the output freezes the whole pipe; nothing is lost.
// Registers (cfg_index): 0 fov_up_angle, 1 fov_down_angle (degrees*256, magnitudes
// used), 2 image_width (capped at 4096), 3 image_height (capped at 256). Write them
// only while no transaction is in flight.
module lidar_spherical_projection_core #(
	parameter int COORD_BITS       = 20,
	parameter int ANGLE_ITERATIONS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [lsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [lsp_pkg::FOV_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_BITS-1:0]          point_x,
	input  logic signed [COORD_BITS-1:0]          point_y,
	input  logic signed [COORD_BITS-1:0]          point_z,
	input  logic                                  last_point,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [lsp_pkg::RANGE_W-1:0]           point_range,
	output logic [lsp_pkg::COL_W-1:0]             pixel_column,
	output logic [lsp_pkg::ROW_W-1:0]             pixel_row,
	output logic [lsp_pkg::INDEX_W-1:0]           pixel_index,
	output logic                                  last_out
);

`include "lidar_spherical_projection_core_defines.svh"

	localparam int SW    = lsp_pkg::SCALE_W;
	localparam int GUARD = SW - COORD_BITS;   // scale shift into the 32-bit frame
	localparam int SQW   = 2 * COORD_BITS;
	localparam int IW    = lsp_pkg::SQRT_IN_W;
	localparam int OW    = lsp_pkg::SQRT_OUT_W;
	localparam int CW    = lsp_pkg::CORDIC_W;
	localparam int AW    = lsp_pkg::ANGLE_W;
	localparam int RNW   = lsp_pkg::RANGE_W;
	localparam int SIDE_W = 3 * SW + 1;

	// Whole pipe advances together; the last mapping stage is the output register.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------- configuration ----------------
	logic [lsp_pkg::FOV_W-1:0]     fov_up_q;
	logic [lsp_pkg::FOV_W-1:0]     fov_down_q;
	logic [lsp_pkg::WIDTH_W-1:0]   width_q;
	logic [lsp_pkg::HEIGHT_W-1:0]  height_q;
	lsp_pkg::cfg_t                 cfg_d;
	lsp_pkg::cfg_t                 cfg_q;
	logic [lsp_pkg::FOV_MAG_W-1:0] up_ext;
	logic [lsp_pkg::FOV_MAG_W-1:0] down_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_up_q   <= lsp_pkg::FOV_UP_RESET;
			fov_down_q <= lsp_pkg::FOV_DOWN_RESET;
			width_q    <= lsp_pkg::WIDTH_RESET;
			height_q   <= lsp_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lsp_pkg::CFG_FOV_UP:       fov_up_q   <= cfg_data;
				lsp_pkg::CFG_FOV_DOWN:     fov_down_q <= cfg_data;
				lsp_pkg::CFG_IMAGE_WIDTH:  width_q    <= cfg_data[lsp_pkg::WIDTH_W-1:0];
				lsp_pkg::CFG_IMAGE_HEIGHT: height_q   <= cfg_data[lsp_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived settings: FOV magnitudes, capped image size, row divisor span, zero flags.
	assign up_ext   = {fov_up_q[lsp_pkg::FOV_W-1], fov_up_q};
	assign down_ext = {fov_down_q[lsp_pkg::FOV_W-1], fov_down_q};

	always_comb begin
		cfg_d.up_mag = fov_up_q[lsp_pkg::FOV_W-1] ? (lsp_pkg::FOV_MAG_W'(0) - up_ext) : up_ext;
		cfg_d.fov_sum = cfg_d.up_mag +
			(fov_down_q[lsp_pkg::FOV_W-1] ? (lsp_pkg::FOV_MAG_W'(0) - down_ext) : down_ext);
		cfg_d.w_eff = (width_q > lsp_pkg::WIDTH_W'(lsp_pkg::MAX_WIDTH)) ?
			lsp_pkg::WIDTH_W'(lsp_pkg::MAX_WIDTH) : width_q;
		cfg_d.h_eff = (height_q > lsp_pkg::HEIGHT_W'(lsp_pkg::MAX_HEIGHT)) ?
			lsp_pkg::HEIGHT_W'(lsp_pkg::MAX_HEIGHT) : height_q;
		cfg_d.h_span   = lsp_pkg::H_SPAN_W'(cfg_d.h_eff) * lsp_pkg::H_SPAN_W'(cfg_d.fov_sum);
		cfg_d.col_zero = (cfg_d.w_eff == '0);
		cfg_d.row_zero = (cfg_d.h_eff == '0) || (cfg_d.fov_sum == '0);
	end

	always_ff @(posedge clk) begin
		cfg_q <= cfg_d;
	end

	// ---------------- s1: squares and scaled coordinates ----------------
	logic signed [SQW-1:0] x2;
	logic signed [SQW-1:0] y2;
	logic signed [SQW-1:0] z2;
	logic signed [SW-1:0]  xs_d;
	logic signed [SW-1:0]  ys_d;
	logic signed [SW-1:0]  zs_d;

	assign x2   = point_x * point_x;
	assign y2   = point_y * point_y;
	assign z2   = point_z * point_z;
	assign xs_d = SW'(point_x) <<< GUARD;
	assign ys_d = SW'(point_y) <<< GUARD;
	assign zs_d = SW'(point_z) <<< GUARD;

	logic                 v_s1;
	logic [SQW-1:0]       sxy_s1;   // x^2 + y^2, unscaled
	logic [SQW-1:0]       sz_s1;
	logic signed [SW-1:0] xs_s1;
	logic signed [SW-1:0] ys_s1;
	logic signed [SW-1:0] zs_s1;
	logic                 last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxy_s1  <= $unsigned(x2) + $unsigned(y2);
			sz_s1   <= $unsigned(z2);
			xs_s1   <= xs_d;
			ys_s1   <= ys_d;
			zs_s1   <= zs_d;
			last_s1 <= last_point;
		end
	end

	// ---------------- square roots: 3D range and scaled horizontal distance ----
	logic [IW-1:0]     rad_range;
	logic [IW-1:0]     rad_horiz;
	logic              sq_v;
	logic [OW-1:0]     root_range;
	logic [OW-1:0]     root_horiz;
	logic [SIDE_W-1:0] sq_side;

	assign rad_range = IW'(sxy_s1) + IW'(sz_s1);
	assign rad_horiz = IW'(sxy_s1) << (2 * GUARD);

	lsp_sqrt_pipe #(
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.rad_a     (rad_range),
		.rad_b     (rad_horiz),
		.side_in   ({xs_s1, ys_s1, zs_s1, last_s1}),
		.out_valid (sq_v),
		.root_a    (root_range),
		.root_b    (root_horiz),
		.side_out  (sq_side)
	);

	// range saturates at the field's top value
	logic [RNW-1:0]       range_sat;
	logic signed [CW-1:0] yaw_x;
	logic signed [CW-1:0] yaw_y;
	logic signed [CW-1:0] pit_x;
	logic signed [CW-1:0] pit_y;

	assign range_sat = (|root_range[OW-1:RNW]) ? '1 : root_range[RNW-1:0];
	assign yaw_x = CW'($signed(sq_side[3*SW:2*SW+1]));
	assign yaw_y = CW'($signed(sq_side[2*SW:SW+1]));
	assign pit_x = $signed({{(CW-OW){1'b0}}, root_horiz});
	assign pit_y = CW'($signed(sq_side[SW:1]));

	// ---------------- CORDIC: yaw = atan2(y, x), pitch = atan2(z, horiz) ----
	logic                 yaw_v;
	logic                 pitch_v;
	logic signed [AW-1:0] yaw_ang;
	logic signed [AW-1:0] pitch_ang;
	logic [RNW-1:0]       range_c;
	logic                 last_c;

	lsp_cordic_pipe #(
		.ITERATIONS (ANGLE_ITERATIONS),
		.SIDE_W     (RNW)
	) u_cordic_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.x_in      (yaw_x),
		.y_in      (yaw_y),
		.side_in   (range_sat),
		.out_valid (yaw_v),
		.angle     (yaw_ang),
		.side_out  (range_c)
	);

	lsp_cordic_pipe #(
		.ITERATIONS (ANGLE_ITERATIONS),
		.SIDE_W     (1)
	) u_cordic_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.x_in      (pit_x),
		.y_in      (pit_y),
		.side_in   (sq_side[0]),
		.out_valid (pitch_v),
		.angle     (pitch_ang),
		.side_out  (last_c)
	);

	// ---------------- pixel mapping and output register ----------------
	lsp_pixel_map u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (yaw_v),
		.yaw          (yaw_ang),
		.pitch        (pitch_ang),
		.range_in     (range_c),
		.last_in      (last_c),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.point_range  (point_range),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.pixel_index  (pixel_index),
		.last_out     (last_out)
	);

	// ---------------- assertions ----------------
	// both CORDIC lanes must stay in lockstep
	`LSP_ASSERT_ALWAYS(a_cordic_lockstep, yaw_v == pitch_v, "CORDIC lanes out of step")
	`LSP_ASSERT_IMPLIES(a_col_in_image, out_valid,
		cfg_q.col_zero ? (pixel_column == '0) :
		(pixel_column <= lsp_pkg::COL_W'(cfg_q.w_eff - lsp_pkg::WIDTH_W'(1))),
		"column outside image")
	`LSP_ASSERT_IMPLIES(a_row_in_image, out_valid,
		cfg_q.row_zero ? (pixel_row == '0) :
		(pixel_row <= lsp_pkg::ROW_W'(cfg_q.h_eff - lsp_pkg::HEIGHT_W'(1))),
		"row outside image")

endmodule

@@ tb/sv/lidar_spherical_projection_core_tb.sv @@
// Testbench for the lidar spherical projection core: directed and random points checked in order.
module lidar_spherical_projection_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 20;
	localparam int ITER = 16;
	localparam int LATENCY = ITER + 47;
	localparam longint HALF = 64'sd2147483648;
	localparam longint QTR = 64'sd1073741824;
	localparam longint TURN_D256 = 64'sd92160;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lsp_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lsp_pkg::FOV_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [CB-1:0] point_x, point_y, point_z;
	logic last_point;
	logic out_valid, out_ready;
	logic [lsp_pkg::RANGE_W-1:0] point_range;
	logic [lsp_pkg::COL_W-1:0] pixel_column;
	logic [lsp_pkg::ROW_W-1:0] pixel_row;
	logic [lsp_pkg::INDEX_W-1:0] pixel_index;
	logic last_out;

	typedef struct packed {
		logic [lsp_pkg::RANGE_W-1:0] rng;
		logic [lsp_pkg::COL_W-1:0] col;
		logic [lsp_pkg::ROW_W-1:0] row;
		logic [lsp_pkg::INDEX_W-1:0] idx;
		logic lst;
	} pixel_t;

	pixel_t pixel_queue[$];
	int errors = 0;
	bit idle_on = 1;

	// Local copy of the four registers
	logic [lsp_pkg::FOV_W-1:0] m_up, m_down;
	logic [lsp_pkg::WIDTH_W-1:0] m_width;
	logic [lsp_pkg::HEIGHT_W-1:0] m_height;

	lidar_spherical_projection_core #(.COORD_BITS(CB), .ANGLE_ITERATIONS(ITER)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z), .last_point(last_point),
		.out_valid(out_valid), .out_ready(out_ready), .point_range(point_range),
		.pixel_column(pixel_column), .pixel_row(pixel_row), .pixel_index(pixel_index),
		.last_out(last_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint fdiv(longint num, longint den);
		if (num >= 0) return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic longint isqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	// Vectoring CORDIC, binary angle with full turn = 2^32
	function automatic longint vector_angle(longint y, longint x);
		longint ang, t, dx, dy;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; ang = QTR;
			end else begin
				x = -y; y = t; ang = -QTR;
			end
		end
		for (int i = 0; i < ITER; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; ang += longint'(lsp_pkg::ATAN_TABLE[i]);
			end else begin
				x -= dx; y += dy; ang -= longint'(lsp_pkg::ATAN_TABLE[i]);
			end
		end
		return ang;
	endfunction

	function automatic pixel_t project_point(logic signed [CB-1:0] px, py, pz, logic lp);
		pixel_t p;
		longint x, y, z, xs, ys, zs, rng, horiz, yaw, pitch, w, h, up, dn, col, row;
		longint num, den, pix;
		x = px; y = py; z = pz;
		xs = x <<< (32 - CB); ys = y <<< (32 - CB); zs = z <<< (32 - CB);
		rng = isqrt(longint'(x * x + y * y + z * z));
		horiz = isqrt(longint'(xs * xs + ys * ys));
		yaw = vector_angle(ys, xs);
		pitch = vector_angle(zs, horiz);
		w = m_width; h = m_height;
		up = longint'($signed(m_up)); dn = longint'($signed(m_down));
		if (w > 4096) w = 4096;
		if (h > 256) h = 256;
		if (up < 0) up = -up;
		if (dn < 0) dn = -dn;
		if (rng > 64'hFFFFF) rng = 64'hFFFFF;
		col = 0; row = 0;
		if (w > 0) begin
			col = fdiv(w * (HALF - yaw), 2 * HALF);
			if (col > w - 1) col = w - 1;
			if (col < 0) col = 0;
		end
		if (h > 0 && up + dn > 0) begin
			num = up * 2 * HALF - pitch * TURN_D256;
			den = (up + dn) * 2 * HALF;
			row = fdiv(h * num, den);
			if (row > h - 1) row = h - 1;
			if (row < 0) row = 0;
		end
		pix = row * w + col;
		p.rng = rng[lsp_pkg::RANGE_W-1:0];
		p.col = col[lsp_pkg::COL_W-1:0];
		p.row = row[lsp_pkg::ROW_W-1:0];
		p.idx = pix[lsp_pkg::INDEX_W-1:0];
		p.lst = lp;
		return p;
	endfunction

	// Receiver: random stalls, checks each result against the oldest prediction
	initial begin
		pixel_t e;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pixel_queue.size() == 0) begin
					$error("unexpected result transaction");
					errors++;
				end else begin
					e = pixel_queue.pop_front();
					if (point_range !== e.rng) begin
						$error("point_range exp %0d got %0d", e.rng, point_range); errors++;
					end
					if (pixel_column !== e.col) begin
						$error("pixel_column exp %0d got %0d", e.col, pixel_column); errors++;
					end
					if (pixel_row !== e.row) begin
						$error("pixel_row exp %0d got %0d", e.row, pixel_row); errors++;
					end
					if (pixel_index !== e.idx) begin
						$error("pixel_index exp %0d got %0d", e.idx, pixel_index); errors++;
					end
					if (last_out !== e.lst) begin
						$error("last_out exp %0d got %0d", e.lst, last_out); errors++;
					end
				end
			end
			out_ready <= !(idle_on && $urandom_range(99) < 9);
		end
	end

	// valid stays high after acceptance until the next idle cycle or drain
	task automatic send_point(logic signed [CB-1:0] px, py, pz, logic lp);
		while (idle_on && $urandom_range(99) < 9) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		point_x <= px; point_y <= py; point_z <= pz; last_point <= lp;
		pixel_queue.insert(pixel_queue.size(), project_point(px, py, pz, lp));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pixel_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// Register write; only called with the pipe empty
	task automatic write_reg(logic [lsp_pkg::CFG_INDEX_W-1:0] idx,
		logic [lsp_pkg::FOV_W-1:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		case (idx)
			lsp_pkg::CFG_FOV_UP:       m_up = val;
			lsp_pkg::CFG_FOV_DOWN:     m_down = val;
			lsp_pkg::CFG_IMAGE_WIDTH:  m_width = val[lsp_pkg::WIDTH_W-1:0];
			lsp_pkg::CFG_IMAGE_HEIGHT: m_height = val[lsp_pkg::HEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [lsp_pkg::FOV_W-1:0] up, dn,
		logic [lsp_pkg::WIDTH_W-1:0] w, logic [lsp_pkg::HEIGHT_W-1:0] h);
		drain();
		write_reg(lsp_pkg::CFG_FOV_UP, up);
		write_reg(lsp_pkg::CFG_FOV_DOWN, dn);
		write_reg(lsp_pkg::CFG_IMAGE_WIDTH, lsp_pkg::FOV_W'(w));
		write_reg(lsp_pkg::CFG_IMAGE_HEIGHT, lsp_pkg::FOV_W'(h));
		cfg_we <= 0;
	endtask

	function automatic logic signed [CB-1:0] rand_coord();
		case ($urandom_range(3))
			0: return CB'($urandom);
			1: return CB'($signed($urandom_range(4000)) - 2000);
			2: return CB'($signed($urandom_range(60000)) - 30000);
			default: return $urandom_range(1) ? CB'(20'sh7FFFF - $urandom_range(50))
				: CB'(20'sh80000 + $urandom_range(50));
		endcase
	endfunction

	// Field extremes, zero vector, axis points and the last-point flag
	task automatic test_directed();
		logic signed [CB-1:0] mx, mn;
		mx = 20'sh7FFFF; mn = 20'sh80000;
		send_point('0, '0, '0, 1'b0);
		send_point('0, '0, '0, 1'b1);
		send_point(mx, mx, mx, 1'b0);
		send_point(mn, mn, mn, 1'b1);
		send_point(mx, '0, '0, 1'b0);
		send_point(mn, '0, '0, 1'b0);
		send_point('0, mx, '0, 1'b0);
		send_point('0, mn, '0, 1'b0);
		send_point('0, '0, mx, 1'b0);
		send_point('0, '0, mn, 1'b0);
		send_point(mn, CB'(-1), '0, 1'b0);
		send_point(mn, CB'(1), '0, 1'b0);
		send_point(CB'(-1), '0, CB'(5), 1'b0);
		send_point(CB'(256), CB'(256), CB'(-256), 1'b1);
		send_point(CB'(1000), CB'(-20), CB'(80), 1'b0);
		send_point(CB'(-1), CB'(-1), CB'(-1), 1'b0);
		send_point(mx, mn, '0, 1'b1);
		send_point(mn, mx, mx, 1'b0);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
	endtask

	// Unthrottled stretch, then pause until the pipe is empty
	task automatic test_full_rate(int n);
		idle_on = 0;
		test_random(n);
		drain();
		idle_on = 1;
	endtask

	initial begin
		arst_n = 0; cfg_we = 0; cfg_index = lsp_pkg::CFG_FOV_UP; cfg_data = 0;
		in_valid = 0; point_x = 0; point_y = 0; point_z = 0; last_point = 0;
		m_up = lsp_pkg::FOV_UP_RESET; m_down = lsp_pkg::FOV_DOWN_RESET;
		m_width = lsp_pkg::WIDTH_RESET; m_height = lsp_pkg::HEIGHT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(150);
		test_full_rate(150);
		// extremes: widest field, largest and beyond-cap sizes
		set_config(16'(23040), 16'(-23040), 13'd8191, 9'd511);
		test_directed();
		test_random(120);
		// minimal image, negative up angle
		set_config(16'(-256), 16'(100), 13'd1, 9'd1);
		test_random(100);
		// zero width and height
		set_config(16'(768), 16'(-6400), 13'd0, 9'd0);
		test_random(60);
		// zero field of view
		set_config(16'd0, 16'd0, 13'd4096, 9'd256);
		test_random(60);
		set_config(lsp_pkg::FOV_W'($urandom_range(23040)),
			lsp_pkg::FOV_W'(-$urandom_range(23040)),
			13'($urandom_range(4096, 1)), 9'($urandom_range(256, 1)));
		test_random(150);
		drain();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/lsp_pkg.sv
rtl/lsp_sqrt_pipe.sv
rtl/lsp_cordic_pipe.sv
rtl/lsp_pixel_map.sv
rtl/lidar_spherical_projection_core.sv
tb/sv/lidar_spherical_projection_core_tb.sv
